### design/lob_pkg.sv
// Shared types, constants and helpers for the limit order book matcher.
package lob_pkg;

  localparam int unsigned LEVEL_COUNT      = 1024;
  localparam int unsigned ORDER_SLOTS      = 4096;
  localparam int unsigned TRADES_PER_MATCH = 64;

  localparam int unsigned LEVEL_W = $clog2(LEVEL_COUNT);
  localparam int unsigned QUEUE_W = LEVEL_W + 1;
  localparam int unsigned SLOT_W  = $clog2(ORDER_SLOTS);
  localparam int unsigned TCNT_W  = $clog2(TRADES_PER_MATCH + 1);
  localparam int unsigned PRICE_W = 24;
  localparam int unsigned QTY_W   = 48;

  localparam logic [PRICE_W-1:0] PRICE_BASE_RESET = 24'd9500;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_MATCH  = 2'd2;

  localparam logic [1:0] KIND_ADD_ACK    = 2'd0;
  localparam logic [1:0] KIND_CANCEL_ACK = 2'd1;
  localparam logic [1:0] KIND_TRADE      = 2'd2;
  localparam logic [1:0] KIND_NO_MATCH   = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_PRICE_OFF  = 3'd1;
  localparam logic [2:0] ST_ZERO_QTY   = 3'd2;
  localparam logic [2:0] ST_POOL_FULL  = 3'd3;
  localparam logic [2:0] ST_UNKNOWN_ID = 3'd4;

  typedef struct packed {
    logic [1:0]         operation;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   quantity;
    logic [11:0]        order_ref;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic [2:0]         status;
    logic [11:0]        assigned_id;
    logic [11:0]        buyer_id;
    logic [11:0]        seller_id;
    logic [PRICE_W-1:0] trade_price;
    logic [QTY_W-1:0]   trade_quantity;
    logic               more_pending;
    logic               last;
  } out_item_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_CLEAR, CMD_LOAD, CMD_ADD_CHECK, CMD_ADD_FIN, CMD_CAN_FIN,
    CMD_SB_READ, CMD_SB_CHECK, CMD_SA_READ, CMD_SA_CHECK, CMD_T_CHECK,
    CMD_T_READ_B, CMD_T_FILL, CMD_T_UPD_B, CMD_T_UPD_A, CMD_M_FIN
  } dp_cmd_e;

  typedef struct packed {
    logic clear_done;
    logic add_reject;
    logic bid_empty;
    logic ask_empty;
    logic head_zero;
    logic trade_go;
  } dp_status_t;

  function automatic out_item_t mk_result(logic [1:0] kind, logic [2:0] st,
                                          logic [11:0] id, logic [11:0] buyer,
                                          logic [11:0] seller, logic [PRICE_W-1:0] px,
                                          logic [QTY_W-1:0] qty, logic more,
                                          logic last_flag);
    out_item_t r;
    r.result_kind    = kind;
    r.status         = st;
    r.assigned_id    = id;
    r.buyer_id       = buyer;
    r.seller_id      = seller;
    r.trade_price    = px;
    r.trade_quantity = qty;
    r.more_pending   = more;
    r.last           = last_flag;
    return r;
  endfunction

endpackage

### design/limit_order_book_matcher.sv
// Top level of the limit order book matcher: controller plus datapath.
// After reset the block sweeps its liveness and level-queue memories, one entry a
// cycle, with busy high. A command is taken when start is high and busy is low. An
// add or a cancel ends in one result, a rejected add too; the unused operation code
// gives no result. A match first steps down over empty ladder levels, reading and
// checking each, to find the best bid and ask, then works one trade at a time,
// limited by the slot memories, which have one read port each and are read once
// for each side of a trade. Results appear for one cycle each under result_valid_o
// and cannot be held off; a trade is shown one step late so that the final one
// carries last and more_pending.
module limit_order_book_matcher (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  lob_pkg::in_item_t           in_i,
  input  logic                        cfg_we_i,
  input  logic [lob_pkg::PRICE_W-1:0] cfg_wdata_i,
  output logic                        result_valid_o,
  output lob_pkg::out_item_t          result_o
);
  import lob_pkg::*;

  dp_cmd_e    cmd;
  dp_status_t status;

  lob_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .operation_i (in_i.operation),
    .status_i    (status),
    .cmd_o       (cmd),
    .busy        (busy)
  );

  lob_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .in_i           (in_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

### design/lob_ctrl.sv
// Controller state machine sequencing add, cancel and match through the datapath.
module lob_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic [1:0]          operation_i,
  input  lob_pkg::dp_status_t status_i,
  output lob_pkg::dp_cmd_e    cmd_o,
  output logic                busy
);
  import lob_pkg::*;

  typedef enum logic [16:0] {
    S_CLEAR   = 17'b00000000000000001,
    S_IDLE    = 17'b00000000000000010,
    S_ADD_CHK = 17'b00000000000000100,
    S_ADD_FIN = 17'b00000000000001000,
    S_CAN_FIN = 17'b00000000000010000,
    S_SB_RD   = 17'b00000000000100000,
    S_SB_CHK  = 17'b00000000001000000,
    S_SA_RD   = 17'b00000000010000000,
    S_SA_CHK  = 17'b00000000100000000,
    S_T_CHK   = 17'b00000001000000000,
    S_T_RDB   = 17'b00000010000000000,
    S_T_FILL  = 17'b00000100000000000,
    S_T_UPB   = 17'b00001000000000000,
    S_T_UPA   = 17'b00010000000000000,
    S_M_FIN   = 17'b00100000000000000,
    S_SPARE_A = 17'b01000000000000000,
    S_SPARE_B = 17'b10000000000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o = CMD_CLEAR;
        if (status_i.clear_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_o = CMD_LOAD;
          unique case (operation_i)
            OP_ADD:    state_d = S_ADD_CHK;
            OP_CANCEL: state_d = S_CAN_FIN;
            OP_MATCH:  state_d = S_SB_RD;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_ADD_CHK: begin
        cmd_o   = CMD_ADD_CHECK;
        state_d = status_i.add_reject ? S_IDLE : S_ADD_FIN;
      end
      S_ADD_FIN: begin
        cmd_o   = CMD_ADD_FIN;
        state_d = S_IDLE;
      end
      S_CAN_FIN: begin
        cmd_o   = CMD_CAN_FIN;
        state_d = S_IDLE;
      end
      S_SB_RD: begin
        cmd_o   = CMD_SB_READ;
        state_d = status_i.bid_empty ? S_SA_RD : S_SB_CHK;
      end
      S_SB_CHK: begin
        cmd_o   = CMD_SB_CHECK;
        state_d = status_i.head_zero ? S_SB_RD : S_SA_RD;
      end
      S_SA_RD: begin
        cmd_o   = CMD_SA_READ;
        state_d = status_i.ask_empty ? S_T_CHK : S_SA_CHK;
      end
      S_SA_CHK: begin
        cmd_o   = CMD_SA_CHECK;
        state_d = status_i.head_zero ? S_SA_RD : S_T_CHK;
      end
      S_T_CHK: begin
        cmd_o   = CMD_T_CHECK;
        state_d = status_i.trade_go ? S_T_RDB : S_M_FIN;
      end
      S_T_RDB: begin
        cmd_o   = CMD_T_READ_B;
        state_d = S_T_FILL;
      end
      S_T_FILL: begin
        cmd_o   = CMD_T_FILL;
        state_d = S_T_UPB;
      end
      S_T_UPB: begin
        cmd_o   = CMD_T_UPD_B;
        state_d = S_T_UPA;
      end
      S_T_UPA: begin
        cmd_o   = CMD_T_UPD_A;
        state_d = S_SB_RD;
      end
      S_M_FIN: begin
        cmd_o   = CMD_M_FIN;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

### design/lob_dp.sv
// Datapath: slot, level and free-list memories, best levels and result register.
module lob_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lob_pkg::dp_cmd_e              cmd_i,
  input  lob_pkg::in_item_t             in_i,
  input  logic                          cfg_we_i,
  input  logic [lob_pkg::PRICE_W-1:0]   cfg_wdata_i,
  output lob_pkg::dp_status_t           status_o,
  output logic                          result_valid_o,
  output lob_pkg::out_item_t            result_o
);
  import lob_pkg::*;

  logic [QUEUE_W-1:0] pos_mem  [0:ORDER_SLOTS-1];
  logic [QTY_W-1:0]   rem_mem  [0:ORDER_SLOTS-1];
  logic               live_mem [0:ORDER_SLOTS-1];
  logic [SLOT_W-1:0]  next_mem [0:ORDER_SLOTS-1];
  logic [SLOT_W-1:0]  prev_mem [0:ORDER_SLOTS-1];
  logic [SLOT_W-1:0]  free_mem [0:ORDER_SLOTS-1];
  logic [SLOT_W-1:0]  head_mem [0:2*LEVEL_COUNT-1];
  logic [SLOT_W-1:0]  tail_mem [0:2*LEVEL_COUNT-1];

  logic [QUEUE_W-1:0] pos_rd;
  logic [QTY_W-1:0]   rem_rd;
  logic               live_rd;
  logic [SLOT_W-1:0]  next_rd, prev_rd, free_rd, head_rd, tail_rd;

  logic               pos_we, rem_we, live_we, next_we, prev_we, free_we, head_we, tail_we;
  logic [SLOT_W-1:0]  pos_wa, rem_wa, live_wa, next_wa, prev_wa, free_wa;
  logic [QUEUE_W-1:0] head_wa, tail_wa;
  logic [QUEUE_W-1:0] pos_wd;
  logic [QTY_W-1:0]   rem_wd;
  logic               live_wd;
  logic [SLOT_W-1:0]  next_wd, prev_wd, free_wd, head_wd, tail_wd;
  logic [SLOT_W-1:0]  next_ra, rem_ra, free_ra;
  logic [QUEUE_W-1:0] head_ra, tail_ra;

  logic [PRICE_W-1:0] base_q;
  in_item_t           item_q;
  logic [SLOT_W:0]    free_cnt_q, fresh_q;
  logic [LEVEL_W:0]   bidp_q, ask_q;
  logic [SLOT_W-1:0]  s_q, t_q, hb_q, ha_q, nb_q, na_q, clr_q;
  logic [QTY_W-1:0]   remb_q, rema_q;
  logic [TCNT_W-1:0]  ntr_q;
  logic               pend_q;
  logic [SLOT_W-1:0]  pb_q, pa_q;
  logic [PRICE_W-1:0] ppx_q;
  logic [QTY_W-1:0]   pfill_q;
  logic               res_valid_q;
  out_item_t          res_q;

  logic [PRICE_W:0]   diff, diff_in;
  logic               price_off;
  logic [LEVEL_W-1:0] lvl;
  logic [QUEUE_W-1:0] q_add;
  logic [2:0]         add_status;
  logic [SLOT_W-1:0]  slot_new;
  logic               crossed, cancel_ok, do_rel;
  logic [SLOT_W-1:0]  rel_s, rel_p, rel_n;
  logic [QUEUE_W-1:0] rel_q;
  logic [LEVEL_W:0]   bid_m1;
  logic [QTY_W-1:0]   fill;

  assign diff      = {1'b0, item_q.price} - {1'b0, base_q};
  assign diff_in   = {1'b0, in_i.price} - {1'b0, base_q};
  assign price_off = diff[PRICE_W] || (diff[PRICE_W-1:0] >= PRICE_W'(LEVEL_COUNT));
  assign lvl       = diff[LEVEL_W-1:0];
  assign q_add     = {item_q.side, lvl};
  assign slot_new  = (free_cnt_q != '0) ? free_rd : fresh_q[SLOT_W-1:0];
  assign bid_m1    = bidp_q - 1'b1;
  assign crossed   = (bidp_q != '0) && (ask_q < (LEVEL_W+1)'(LEVEL_COUNT)) && (bidp_q > ask_q);
  assign cancel_ok = (item_q.order_ref != '0) && live_rd;
  assign fill      = (remb_q < rem_rd) ? remb_q : rem_rd;

  always_comb begin
    priority if (price_off)                                 add_status = ST_PRICE_OFF;
    else if (item_q.quantity == '0)                         add_status = ST_ZERO_QTY;
    else if (free_cnt_q == '0 &&
             fresh_q == (SLOT_W+1)'(ORDER_SLOTS))           add_status = ST_POOL_FULL;
    else                                                    add_status = ST_OK;
  end

  assign status_o.clear_done = (clr_q == '1);
  assign status_o.add_reject = (add_status != ST_OK);
  assign status_o.bid_empty  = (bidp_q == '0);
  assign status_o.ask_empty  = (ask_q == (LEVEL_W+1)'(LEVEL_COUNT));
  assign status_o.head_zero  = (head_rd == '0);
  assign status_o.trade_go   = crossed && (ntr_q < TCNT_W'(TRADES_PER_MATCH));

  assign free_ra = SLOT_W'(free_cnt_q - 1'b1);
  assign tail_ra = {in_i.side, diff_in[LEVEL_W-1:0]};
  assign next_ra = (cmd_i == CMD_T_CHECK) ? hb_q :
                   (cmd_i == CMD_T_READ_B) ? ha_q : in_i.order_ref;
  assign rem_ra  = (cmd_i == CMD_T_CHECK) ? hb_q : ha_q;
  assign head_ra = (cmd_i == CMD_SA_READ) ? {1'b1, ask_q[LEVEL_W-1:0]}
                                          : {1'b0, bid_m1[LEVEL_W-1:0]};

  always_comb begin
    rel_s  = item_q.order_ref;
    rel_q  = pos_rd;
    rel_p  = prev_rd;
    rel_n  = next_rd;
    do_rel = 1'b0;
    unique case (cmd_i)
      CMD_CAN_FIN: do_rel = cancel_ok;
      CMD_T_UPD_B: begin
        rel_s  = hb_q;
        rel_q  = {1'b0, bid_m1[LEVEL_W-1:0]};
        rel_p  = '0;
        rel_n  = nb_q;
        do_rel = (remb_q == '0);
      end
      CMD_T_UPD_A: begin
        rel_s  = ha_q;
        rel_q  = {1'b1, ask_q[LEVEL_W-1:0]};
        rel_p  = '0;
        rel_n  = na_q;
        do_rel = (rema_q == '0);
      end
      default: ;
    endcase
  end

  always_comb begin
    pos_we = 1'b0; pos_wa = '0; pos_wd = '0;
    rem_we = 1'b0; rem_wa = '0; rem_wd = '0;
    live_we = 1'b0; live_wa = '0; live_wd = 1'b0;
    next_we = 1'b0; next_wa = '0; next_wd = '0;
    prev_we = 1'b0; prev_wa = '0; prev_wd = '0;
    free_we = 1'b0; free_wa = '0; free_wd = '0;
    head_we = 1'b0; head_wa = '0; head_wd = '0;
    tail_we = 1'b0; tail_wa = '0; tail_wd = '0;
    unique case (cmd_i)
      CMD_CLEAR: begin
        live_we = 1'b1; live_wa = clr_q;
        head_we = 1'b1; head_wa = clr_q[QUEUE_W-1:0];
        tail_we = 1'b1; tail_wa = clr_q[QUEUE_W-1:0];
      end
      CMD_ADD_CHECK: begin
        if (add_status == ST_OK) begin
          pos_we  = 1'b1; pos_wa  = slot_new; pos_wd  = q_add;
          rem_we  = 1'b1; rem_wa  = slot_new; rem_wd  = item_q.quantity;
          live_we = 1'b1; live_wa = slot_new; live_wd = 1'b1;
          next_we = 1'b1; next_wa = slot_new; next_wd = '0;
          prev_we = 1'b1; prev_wa = slot_new; prev_wd = tail_rd;
          tail_we = 1'b1; tail_wa = q_add;    tail_wd = slot_new;
          if (tail_rd == '0) begin
            head_we = 1'b1; head_wa = q_add; head_wd = slot_new;
          end
        end
      end
      CMD_ADD_FIN: begin
        if (t_q != '0) begin
          next_we = 1'b1; next_wa = t_q; next_wd = s_q;
        end
      end
      CMD_T_UPD_B: begin
        if (remb_q != '0) begin
          rem_we = 1'b1; rem_wa = hb_q; rem_wd = remb_q;
        end
      end
      CMD_T_UPD_A: begin
        if (rema_q != '0) begin
          rem_we = 1'b1; rem_wa = ha_q; rem_wd = rema_q;
        end
      end
      default: ;
    endcase
    if (do_rel) begin
      if (rel_p != '0) begin
        next_we = 1'b1; next_wa = rel_p; next_wd = rel_n;
      end else begin
        head_we = 1'b1; head_wa = rel_q; head_wd = rel_n;
      end
      if (rel_n != '0) begin
        prev_we = 1'b1; prev_wa = rel_n; prev_wd = rel_p;
      end else begin
        tail_we = 1'b1; tail_wa = rel_q; tail_wd = rel_p;
      end
      live_we = 1'b1; live_wa = rel_s; live_wd = 1'b0;
      if (free_cnt_q < (SLOT_W+1)'(ORDER_SLOTS)) begin
        free_we = 1'b1; free_wa = free_cnt_q[SLOT_W-1:0]; free_wd = rel_s;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    pos_rd <= pos_mem[in_i.order_ref];
  end

  always_ff @(posedge clk_i) begin
    if (rem_we) rem_mem[rem_wa] <= rem_wd;
    rem_rd <= rem_mem[rem_ra];
  end

  always_ff @(posedge clk_i) begin
    if (live_we) live_mem[live_wa] <= live_wd;
    live_rd <= live_mem[in_i.order_ref];
  end

  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    next_rd <= next_mem[next_ra];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    prev_rd <= prev_mem[in_i.order_ref];
  end

  always_ff @(posedge clk_i) begin
    if (free_we) free_mem[free_wa] <= free_wd;
    free_rd <= free_mem[free_ra];
  end

  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd <= head_mem[head_ra];
  end

  always_ff @(posedge clk_i) begin
    if (tail_we) tail_mem[tail_wa] <= tail_wd;
    tail_rd <= tail_mem[tail_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= PRICE_BASE_RESET;
      free_cnt_q  <= '0;
      fresh_q     <= (SLOT_W+1)'(1);
      bidp_q      <= '0;
      ask_q       <= (LEVEL_W+1)'(LEVEL_COUNT);
      ntr_q       <= '0;
      pend_q      <= 1'b0;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      if (cfg_we_i) base_q <= cfg_wdata_i;
      unique case (cmd_i)
        CMD_CLEAR: clr_q <= clr_q + 1'b1;
        CMD_LOAD: begin
          ntr_q  <= '0;
          pend_q <= 1'b0;
        end
        CMD_ADD_CHECK: begin
          if (add_status != ST_OK) begin
            res_valid_q <= 1'b1;
          end else if (free_cnt_q != '0) begin
            free_cnt_q <= free_cnt_q - 1'b1;
          end else begin
            fresh_q <= fresh_q + 1'b1;
          end
        end
        CMD_ADD_FIN: begin
          res_valid_q <= 1'b1;
          if (!item_q.side) begin
            if ({1'b0, lvl} + 1'b1 > bidp_q) bidp_q <= {1'b0, lvl} + 1'b1;
          end else if ({1'b0, lvl} < ask_q) begin
            ask_q <= {1'b0, lvl};
          end
        end
        CMD_CAN_FIN: res_valid_q <= 1'b1;
        CMD_SB_CHECK: if (head_rd == '0) bidp_q <= bid_m1;
        CMD_SA_CHECK: if (head_rd == '0) ask_q <= ask_q + 1'b1;
        CMD_T_FILL: begin
          res_valid_q <= pend_q;
          pend_q      <= 1'b1;
          ntr_q       <= ntr_q + 1'b1;
        end
        CMD_M_FIN: begin
          res_valid_q <= 1'b1;
          pend_q      <= 1'b0;
        end
        default: ;
      endcase
      if (do_rel && free_cnt_q < (SLOT_W+1)'(ORDER_SLOTS)) free_cnt_q <= free_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      CMD_LOAD: item_q <= in_i;
      CMD_ADD_CHECK: begin
        s_q   <= slot_new;
        t_q   <= tail_rd;
        res_q <= mk_result(KIND_ADD_ACK, add_status, '0, '0, '0, '0, '0, 1'b0, 1'b1);
      end
      CMD_ADD_FIN:
        res_q <= mk_result(KIND_ADD_ACK, ST_OK, s_q, '0, '0, '0, '0, 1'b0, 1'b1);
      CMD_CAN_FIN:
        res_q <= mk_result(KIND_CANCEL_ACK, cancel_ok ? ST_OK : ST_UNKNOWN_ID,
                           item_q.order_ref, '0, '0, '0, '0, 1'b0, 1'b1);
      CMD_SB_CHECK: hb_q <= head_rd;
      CMD_SA_CHECK: ha_q <= head_rd;
      CMD_T_READ_B: begin
        remb_q <= rem_rd;
        nb_q   <= next_rd;
      end
      CMD_T_FILL: begin
        res_q   <= mk_result(KIND_TRADE, ST_OK, '0, pb_q, pa_q, ppx_q, pfill_q, 1'b0, 1'b0);
        remb_q  <= remb_q - fill;
        rema_q  <= rem_rd - fill;
        na_q    <= next_rd;
        pb_q    <= hb_q;
        pa_q    <= ha_q;
        ppx_q   <= base_q + PRICE_W'(ask_q);
        pfill_q <= fill;
      end
      CMD_M_FIN: begin
        if (pend_q) begin
          res_q <= mk_result(KIND_TRADE, ST_OK, '0, pb_q, pa_q, ppx_q, pfill_q,
                             (ntr_q == TCNT_W'(TRADES_PER_MATCH)) && crossed, 1'b1);
        end else begin
          res_q <= mk_result(KIND_NO_MATCH, ST_OK, '0, '0, '0, '0, '0, 1'b0, 1'b1);
        end
      end
      default: ;
    endcase
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule
